/* hw/rtl/rsmp_pkg.sv */
package rsmp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 18;
    localparam int PHASE_W  = 19;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int FRAC_W   = 16;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [PHASE_W-1:0] ONE_Q16   = PHASE_W'(1) << FRAC_W;
    localparam logic [STEP_W-1:0]  STEP_INIT = STEP_W'(44685);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_frame;

    typedef struct packed {
        t_frame prev;
        t_frame cur;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // prev + prod / 2^16, the sum truncated toward zero
    function automatic logic signed [SAMPLE_W-1:0] lerp_fin(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [PROD_W-1:0]   prod
    );
        logic signed [PROD_W:0]    num;
        logic [SAMPLE_W-1:0]       q;
        logic                      rnd;
        num = $signed({{(PROD_W + 1 - SAMPLE_W - FRAC_W){a[SAMPLE_W-1]}}, a,
                       {FRAC_W{1'b0}}}) + $signed({prod[PROD_W-1], prod});
        rnd = num[PROD_W] && (num[FRAC_W-1:0] != '0);
        q   = num[FRAC_W +: SAMPLE_W] + SAMPLE_W'(rnd);
        return $signed(q);
    endfunction

endpackage

/* hw/rtl/linear_interp_stereo_resampler.sv */
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_left_in, i_right_in
// output    o_out_valid / i_out_ready    o_left_out, o_right_out, o_last_of_run
// config    i_cfg_we                     i_cfg_data (phase_step)
//
// Each output passes through the back-end states S_MUL (one multiply) and S_OUT
// (one finalize into the output register).
// The front accepts frames into a 2-entry queue regardless of the back end.
// Synchronous active-low reset; no clearing pass, the block is ready right away.
// A stalled output holds the back end; the front stalls only when the queue fills.
module linear_interp_stereo_resampler
    import rsmp_pkg::*;
#(
    parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_left_in,
    input  logic signed [SAMPLE_W-1:0] i_right_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    output logic                       o_last_of_run,
    input  logic                       i_cfg_we,
    input  logic [STEP_W-1:0]          i_cfg_data
);

    t_frame  w_frame;
    t_q_stat w_q_stat;
    logic    w_push;
    t_pair   w_push_data;
    logic    w_pop;
    t_pair   w_pop_data;

    assign w_frame.left  = i_left_in;
    assign w_frame.right = i_right_in;

    rsmp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_frame     (w_frame),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    rsmp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    rsmp_back #(
        .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_q_stat      (w_q_stat),
        .i_pop_data    (w_pop_data),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* hw/rtl/rsmp_front.sv */
module rsmp_front
    import rsmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_frame  i_frame,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_pair   o_push_data
);

    logic   r_primed;
    t_frame r_prev;
    logic   w_accept;

    assign o_in_ready = !i_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    // the first frame only primes the history and never enters the queue
    assign o_push           = w_accept && r_primed;
    assign o_push_data.prev = r_prev;
    assign o_push_data.cur  = i_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_prev   <= '0;
        end else if (w_accept) begin
            r_primed <= 1'b1;
            r_prev   <= i_frame;
        end
    end

endmodule

/* hw/rtl/rsmp_queue.sv */
module rsmp_queue
    import rsmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pair   i_push_data,
    input  logic    i_pop,
    output t_pair   o_pop_data,
    output t_q_stat o_stat
);

    t_pair             r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pop_data   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
    end

endmodule

/* hw/rtl/rsmp_back.sv */
module rsmp_back
    import rsmp_pkg::*;
#(
    parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [STEP_W-1:0]          i_cfg_data,
    input  t_q_stat                    i_q_stat,
    input  t_pair                      i_pop_data,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    output logic                       o_last_of_run
);

    localparam int CNT_W = $clog2(MAX_OUTPUTS_PER_INPUT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [STEP_W-1:0]          r_step;
    logic [PHASE_W-1:0]         r_phase;
    logic [PHASE_W-1:0]         r_nphase;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_last;
    t_frame                     r_prev;
    logic signed [DIFF_W-1:0]   r_diff_l;
    logic signed [DIFF_W-1:0]   r_diff_r;
    logic signed [PROD_W-1:0]   r_prod_l;
    logic signed [PROD_W-1:0]   r_prod_r;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l;
    logic signed [SAMPLE_W-1:0] r_out_r;
    logic                       r_out_last;

    logic [PHASE_W-1:0]         w_nphase;
    logic [CNT_W-1:0]           w_ncnt;
    logic signed [DIFF_W-1:0]   w_phase_s;
    logic                       w_slot_free;

    assign o_pop         = (r_state == S_IDLE) && !i_q_stat.empty;
    assign w_nphase      = r_phase + PHASE_W'(r_step);
    assign w_ncnt        = r_cnt + 1'b1;
    assign w_phase_s     = $signed({1'b0, r_phase[FRAC_W-1:0]});
    assign w_slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_left_out    = r_out_l;
    assign o_right_out   = r_out_r;
    assign o_last_of_run = r_out_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop && (r_phase < ONE_Q16)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_slot_free) begin
                    n_state = r_last ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_INIT;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && !((r_state == S_OUT) && w_slot_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    // phase already at or past 1.0: frame yields nothing
                    if (o_pop && (r_phase >= ONE_Q16)) begin
                        r_phase <= r_phase - ONE_Q16;
                    end
                end
                S_MUL: begin
                    r_cnt <= w_ncnt;
                end
                S_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        if (!r_last) begin
                            r_phase <= r_nphase;
                        end else if (r_nphase >= ONE_Q16) begin
                            r_phase <= r_nphase - ONE_Q16;
                        end else begin
                            r_phase <= '0;
                        end
                    end
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prev   <= i_pop_data.prev;
            r_diff_l <= DIFF_W'(i_pop_data.cur.left) - DIFF_W'(i_pop_data.prev.left);
            r_diff_r <= DIFF_W'(i_pop_data.cur.right) - DIFF_W'(i_pop_data.prev.right);
        end
        if (r_state == S_MUL) begin
            r_prod_l <= r_diff_l * w_phase_s;
            r_prod_r <= r_diff_r * w_phase_s;
            r_nphase <= w_nphase;
            r_last   <= (w_nphase >= ONE_Q16)
                        || (w_ncnt == CNT_W'(MAX_OUTPUTS_PER_INPUT));
        end
        if ((r_state == S_OUT) && w_slot_free) begin
            r_out_l    <= lerp_fin(r_prev.left, r_prod_l);
            r_out_r    <= lerp_fin(r_prev.right, r_prod_r);
            r_out_last <= r_last;
        end
    end

    a_mul_phase_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_phase < ONE_Q16))
        else $error("interpolation started with phase at or above 1.0");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_OUTPUTS_PER_INPUT))
        else $error("output count exceeded cap");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result dropped while output stalled");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> ((r_state == S_IDLE) && !r_last || (r_state == S_IDLE)))
        else $error("queue popped while busy");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

endmodule
